/* rtl/sbpr_pkg.sv */
// shared constants, item types and command codes of the serial bridge
package sbpr_pkg;

   // ring and packet geometry
   localparam int TX_DEPTH_LOG2 = 11;
   localparam int RX_DEPTH_LOG2 = 9;
   localparam int PACKET_BYTES  = 64;
   localparam int PKT_CNT_W     = $clog2(PACKET_BYTES + 1);

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // result field widths fixed by the interface
   localparam int AVAIL_W = 9;
   localparam int BAUD_W  = 32;

   // action codes on the request channel
   localparam logic [2:0] ACT_APP_WRITE  = 3'd0;
   localparam logic [2:0] ACT_APP_READ   = 3'd1;
   localparam logic [2:0] ACT_HOST_OUT   = 3'd2;
   localparam logic [2:0] ACT_IN_TAKEN   = 3'd3;
   localparam logic [2:0] ACT_CONFIGURE  = 3'd4;
   localparam logic [2:0] ACT_BUS_RESET  = 3'd5;
   localparam logic [2:0] ACT_LINE_STATE = 3'd6;
   localparam logic [2:0] ACT_SET_BAUD   = 3'd7;

   // line coding values
   localparam logic [BAUD_W-1:0] BAUD_TOUCH   = 32'd1200;
   localparam logic [BAUD_W-1:0] BAUD_DEFAULT = 32'd115200;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_PACKET = 1'b1;

   // one-hot class of a command
   typedef struct packed {
      logic app_write;
      logic app_read;
      logic host_out;
      logic in_taken;
      logic configure;
      logic bus_reset;
      logic line_state;
      logic set_baud;
   } op_type;

   // classified command passed from front to back
   typedef struct packed {
      op_type             op;
      logic [7:0]         data_byte;
      logic               burst_end;
      logic               dtr_bit;
      logic [BAUD_W-1:0]  new_baud;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic               kind;
      logic [7:0]         out_byte;
      logic               read_valid;
      logic               write_accepted;
      logic               run_last;
      logic               rearm_out;
      logic               reboot_request;
      logic               connected;
      logic [AVAIL_W-1:0] rx_available;
      logic [BAUD_W-1:0]  baud_rate;
   } rsp_type;

endpackage

/* rtl/sbpr_front.sv */
// request intake: classifies each item and queues it for the back end
module sbpr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [2:0]            req_action,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_burst_end,
   input  logic                  req_dtr_bit,
   input  logic [31:0]           req_new_baud,
   output sbpr_pkg::cmd_type     cmd,
   output logic                  cmd_valid,
   input  logic                  cmd_pop
);

   sbpr_pkg::cmd_type                  cmdq_ff [sbpr_pkg::CMDQ_DEPTH];
   sbpr_pkg::cmd_type                  cmd_new;
   logic [sbpr_pkg::CMDQ_PTR_W-1:0]    head_ff, head_in;
   logic [sbpr_pkg::CMDQ_PTR_W-1:0]    tail_ff, tail_in;
   logic [sbpr_pkg::CMDQ_CNT_W-1:0]    count_ff, count_in;
   logic                               push_ok;
   logic                               pop_ok;

   // classify the action into a one-hot command
   always_comb begin
      cmd_new           = '0;
      cmd_new.data_byte = req_data_byte;
      cmd_new.burst_end = req_burst_end;
      cmd_new.dtr_bit   = req_dtr_bit;
      cmd_new.new_baud  = req_new_baud;
      unique case (req_action)
         sbpr_pkg::ACT_APP_WRITE:  cmd_new.op.app_write  = 1'b1;
         sbpr_pkg::ACT_APP_READ:   cmd_new.op.app_read   = 1'b1;
         sbpr_pkg::ACT_HOST_OUT:   cmd_new.op.host_out   = 1'b1;
         sbpr_pkg::ACT_IN_TAKEN:   cmd_new.op.in_taken   = 1'b1;
         sbpr_pkg::ACT_CONFIGURE:  cmd_new.op.configure  = 1'b1;
         sbpr_pkg::ACT_BUS_RESET:  cmd_new.op.bus_reset  = 1'b1;
         sbpr_pkg::ACT_LINE_STATE: cmd_new.op.line_state = 1'b1;
         sbpr_pkg::ACT_SET_BAUD:   cmd_new.op.set_baud   = 1'b1;
         default:                  cmd_new.op.set_baud   = 1'b1;
      endcase
   end

   // queue handshake
   assign req_full  = (count_ff == sbpr_pkg::CMDQ_CNT_W'(sbpr_pkg::CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;
   assign cmd       = cmdq_ff[head_ff];

   // queue pointers
   always_comb begin
      head_in  = pop_ok  ? head_ff + 1'b1 : head_ff;
      tail_in  = push_ok ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         cmdq_ff[tail_ff] <= cmd_new;
      end
   end

   // a queued command carries exactly one class
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> $onehot(cmd.op))
      else $error("queued command has no single class");

   // fill level never passes the queue depth
   a_cmdq_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sbpr_pkg::CMDQ_CNT_W'(sbpr_pkg::CMDQ_DEPTH))
      else $error("command queue overfilled");

endmodule

/* rtl/sbpr_back.sv */
// execution: rings, link state, packet sequencer and result register
module sbpr_back (
   input  logic                clock,
   input  logic                reset,
   input  sbpr_pkg::cmd_type   cmd,
   input  logic                cmd_valid,
   output logic                cmd_pop,
   input  logic                rsp_pop,
   output logic                rsp_valid,
   output sbpr_pkg::rsp_type   rsp
);

   localparam int TXW = sbpr_pkg::TX_DEPTH_LOG2;
   localparam int RXW = sbpr_pkg::RX_DEPTH_LOG2;
   localparam int PCW = sbpr_pkg::PKT_CNT_W;
   localparam logic [TXW-1:0] TX_MASK = '1;
   localparam logic [RXW-1:0] RX_MASK = '1;
   localparam logic [PCW-1:0] PKT_MAX = PCW'(sbpr_pkg::PACKET_BYTES);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_PKT  = 2'd2;

   logic [7:0]        tx_mem [2**TXW];
   logic [7:0]        rx_mem [2**RXW];

   logic [1:0]        st_ff, st_in;
   logic [TXW-1:0]    tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic              tx_flight_ff, tx_flight_in;
   logic [RXW-1:0]    rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic              rx_paused_ff, rx_paused_in;
   logic              dtr_ff, dtr_in;
   logic              cfg_ff, cfg_in;
   logic [31:0]       baud_ff, baud_in;
   logic [PCW-1:0]    out_count_ff, out_count_in;
   logic [PCW-1:0]    pkt_len_ff, pkt_len_in;
   logic [PCW-1:0]    pkt_idx_ff, pkt_idx_in;
   logic [TXW-1:0]    pkt_addr_ff, pkt_addr_in;
   sbpr_pkg::rsp_type snap_ff, snap_in;
   logic              out_valid_ff, out_valid_in;
   sbpr_pkg::rsp_type out_rec_ff, out_rec_in;
   logic [7:0]        tx_rd_ff, tx_rd_in;
   logic [7:0]        rx_rd_ff;

   logic              slot_free;
   logic              tx_we, tx_re, rx_we, rx_re;
   logic [TXW-1:0]    tx_raddr;

   assign slot_free = !out_valid_ff || rsp_pop;

   // command execution and result sequencing
   always_comb begin
      logic              launch_try;
      logic              flight_v;
      logic [TXW-1:0]    tx_used_v;
      logic [RXW-1:0]    rx_used_v;
      logic [RXW-1:0]    rx_room_v;
      logic [PCW-1:0]    n_v;
      logic              wacc, rvalid, rearm, reboot;
      sbpr_pkg::rsp_type rec;

      launch_try   = 1'b0;
      flight_v     = tx_flight_ff;
      tx_used_v    = '0;
      rx_used_v    = '0;
      rx_room_v    = '0;
      n_v          = '0;
      wacc         = 1'b0;
      rvalid       = 1'b0;
      rearm        = 1'b0;
      reboot       = 1'b0;
      rec          = '0;

      st_in        = st_ff;
      tx_wp_in     = tx_wp_ff;
      tx_rp_in     = tx_rp_ff;
      tx_flight_in = tx_flight_ff;
      rx_wp_in     = rx_wp_ff;
      rx_rp_in     = rx_rp_ff;
      rx_paused_in = rx_paused_ff;
      dtr_in       = dtr_ff;
      cfg_in       = cfg_ff;
      baud_in      = baud_ff;
      out_count_in = out_count_ff;
      pkt_len_in   = pkt_len_ff;
      pkt_idx_in   = pkt_idx_ff;
      pkt_addr_in  = pkt_addr_ff;
      snap_in      = snap_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_rec_in   = out_rec_ff;
      cmd_pop      = 1'b0;
      tx_we        = 1'b0;
      tx_re        = 1'b0;
      rx_we        = 1'b0;
      rx_re        = 1'b0;
      tx_raddr     = pkt_addr_ff + 1'b1;

      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               // state update for the command class
               if (cmd.op.app_write) begin
                  if (cfg_ff) begin
                     if ((tx_wp_ff - tx_rp_ff) != TX_MASK) begin
                        tx_we    = 1'b1;
                        tx_wp_in = tx_wp_ff + 1'b1;
                        wacc     = 1'b1;
                     end
                     launch_try = cmd.burst_end;
                  end
               end else if (cmd.op.app_read) begin
                  if (rx_wp_ff != rx_rp_ff) begin
                     rx_re    = 1'b1;
                     rx_rp_in = rx_rp_ff + 1'b1;
                     rvalid   = 1'b1;
                  end
                  rx_room_v = RX_MASK - (rx_wp_ff - rx_rp_in);
                  if (rx_paused_ff && (32'(rx_room_v) >= sbpr_pkg::PACKET_BYTES)) begin
                     rx_paused_in = 1'b0;
                     rearm        = 1'b1;
                  end
               end else if (cmd.op.host_out) begin
                  if (out_count_ff < PKT_MAX) begin
                     if ((rx_wp_ff - rx_rp_ff) != RX_MASK) begin
                        rx_we    = 1'b1;
                        rx_wp_in = rx_wp_ff + 1'b1;
                     end
                     out_count_in = out_count_ff + 1'b1;
                  end
                  if (cmd.burst_end) begin
                     out_count_in = '0;
                     rx_room_v    = RX_MASK - (rx_wp_in - rx_rp_ff);
                     if (32'(rx_room_v) >= sbpr_pkg::PACKET_BYTES) begin
                        rearm = 1'b1;
                     end else begin
                        rx_paused_in = 1'b1;
                     end
                  end
               end else if (cmd.op.in_taken) begin
                  flight_v     = 1'b0;
                  tx_flight_in = 1'b0;
                  launch_try   = 1'b1;
               end else if (cmd.op.configure) begin
                  cfg_in = 1'b1;
                  rearm  = 1'b1;
               end else if (cmd.op.bus_reset) begin
                  tx_wp_in     = '0;
                  tx_rp_in     = '0;
                  rx_wp_in     = '0;
                  rx_rp_in     = '0;
                  tx_flight_in = 1'b0;
                  rx_paused_in = 1'b0;
                  dtr_in       = 1'b0;
                  cfg_in       = 1'b0;
                  out_count_in = '0;
               end else if (cmd.op.line_state) begin
                  dtr_in = cmd.dtr_bit;
                  reboot = !cmd.dtr_bit && (baud_ff == sbpr_pkg::BAUD_TOUCH);
               end else begin
                  baud_in = cmd.new_baud;
               end

               // packet launch check on the updated transmit ring
               tx_used_v = tx_wp_in - tx_rp_ff;
               if (32'(tx_used_v) > sbpr_pkg::PACKET_BYTES) begin
                  n_v = PKT_MAX;
               end else begin
                  n_v = PCW'(tx_used_v);
               end
               launch_try = launch_try && !flight_v && cfg_ff && (tx_used_v != '0);
               if (launch_try) begin
                  tx_rp_in     = tx_rp_ff + TXW'(n_v);
                  tx_flight_in = 1'b1;
               end

               // status seen after the command
               rx_used_v          = rx_wp_in - rx_rp_in;
               rec.kind           = sbpr_pkg::KIND_STATUS;
               rec.out_byte       = '0;
               rec.read_valid     = 1'b0;
               rec.write_accepted = wacc;
               rec.run_last       = 1'b1;
               rec.rearm_out      = rearm;
               rec.reboot_request = reboot;
               rec.connected      = cfg_in && dtr_in;
               rec.rx_available   = sbpr_pkg::AVAIL_W'(rx_used_v);
               rec.baud_rate      = baud_in;

               if (launch_try) begin
                  snap_in     = rec;
                  pkt_len_in  = n_v;
                  pkt_idx_in  = '0;
                  pkt_addr_in = tx_rp_ff;
                  tx_re       = 1'b1;
                  tx_raddr    = tx_rp_ff;
                  st_in       = ST_PKT;
               end else if (rvalid) begin
                  snap_in = rec;
                  st_in   = ST_READ;
               end else begin
                  out_valid_in = 1'b1;
                  out_rec_in   = rec;
               end
            end
         end
         ST_READ: begin
            // read byte arrives from the receive ring
            if (slot_free) begin
               rec            = snap_ff;
               rec.out_byte   = rx_rd_ff;
               rec.read_valid = 1'b1;
               out_valid_in   = 1'b1;
               out_rec_in     = rec;
               st_in          = ST_IDLE;
            end
         end
         ST_PKT: begin
            // one packet byte per free slot
            if (slot_free) begin
               rec            = snap_ff;
               rec.kind       = sbpr_pkg::KIND_PACKET;
               rec.out_byte   = tx_rd_ff;
               rec.read_valid = 1'b0;
               rec.run_last   = (pkt_idx_ff == pkt_len_ff - 1'b1);
               out_valid_in   = 1'b1;
               out_rec_in     = rec;
               if (rec.run_last) begin
                  st_in = ST_IDLE;
               end else begin
                  pkt_idx_in  = pkt_idx_ff + 1'b1;
                  pkt_addr_in = pkt_addr_ff + 1'b1;
                  tx_re       = 1'b1;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         tx_wp_ff     <= '0;
         tx_rp_ff     <= '0;
         tx_flight_ff <= 1'b0;
         rx_wp_ff     <= '0;
         rx_rp_ff     <= '0;
         rx_paused_ff <= 1'b0;
         dtr_ff       <= 1'b0;
         cfg_ff       <= 1'b0;
         baud_ff      <= sbpr_pkg::BAUD_DEFAULT;
         out_count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         tx_wp_ff     <= tx_wp_in;
         tx_rp_ff     <= tx_rp_in;
         tx_flight_ff <= tx_flight_in;
         rx_wp_ff     <= rx_wp_in;
         rx_rp_ff     <= rx_rp_in;
         rx_paused_ff <= rx_paused_in;
         dtr_ff       <= dtr_in;
         cfg_ff       <= cfg_in;
         baud_ff      <= baud_in;
         out_count_ff <= out_count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pkt_len_ff  <= pkt_len_in;
      pkt_idx_ff  <= pkt_idx_in;
      pkt_addr_ff <= pkt_addr_in;
      snap_ff     <= snap_in;
      out_rec_ff  <= out_rec_in;
   end

   // transmit ring, with bypass when a launch reads the byte being written
   assign tx_rd_in = (tx_we && (tx_raddr == tx_wp_ff)) ? cmd.data_byte : tx_mem[tx_raddr];

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wp_ff] <= cmd.data_byte;
      end
      if (tx_re) begin
         tx_rd_ff <= tx_rd_in;
      end
   end

   // receive ring
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wp_ff] <= cmd.data_byte;
      end
      if (rx_re) begin
         rx_rd_ff <= rx_mem[rx_rp_ff];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_rec_ff;

   // packet index stays inside the packet
   a_pkt_idx: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_PKT) |-> (pkt_idx_ff < pkt_len_ff))
      else $error("packet index past packet length");

   // a packet in progress is never empty or oversized
   a_pkt_len: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_PKT) |-> ((pkt_len_ff != '0) && (pkt_len_ff <= PKT_MAX)))
      else $error("bad packet length");

   // a launch always marks a packet in flight
   a_launch_flight: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == ST_IDLE) && (st_in == ST_PKT)) |=> tx_flight_ff)
      else $error("packet launched without in-flight mark");

   // out packet byte count stays bounded
   a_out_count: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= PKT_MAX)
      else $error("out packet byte count overflow");

endmodule

/* rtl/serial_bridge_packet_rings_core.sv */
// top level of the serial bridge with transmit and receive byte rings
//
// Both channels are queues. An item enters on req_* when req_push is high
// and req_full is low; results leave on rsp_* while rsp_empty is low and are
// taken when rsp_pop is high. The front end classifies each item and puts it
// in a two-entry command queue; the back end runs it against the rings and
// link state and writes results into a one-entry output register.
// A status result passes from the command queue through the back end into the
// output register; a read byte also passes the registered receive ring read,
// and IN packet bytes the registered transmit ring read. Status-only items run
// one per cycle while the output register drains; no new item is taken while
// a read byte or a packet goes out; the packet sequencer reads the transmit
// ring by its single registered port, one byte a cycle while the slot is free.
// When the receiver stops popping, the output register holds its result,
// the back end stalls, the command queue fills and req_full rises.
// Reset empties both rings and the queues, clears link state and sets the
// baud rate to 115200; ring storage itself is not cleared.
module serial_bridge_packet_rings_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_burst_end,
   input  logic        req_dtr_bit,
   input  logic [31:0] req_new_baud,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_read_valid,
   output logic        rsp_write_accepted,
   output logic        rsp_run_last,
   output logic        rsp_rearm_out,
   output logic        rsp_reboot_request,
   output logic        rsp_connected,
   output logic [8:0]  rsp_rx_available,
   output logic [31:0] rsp_baud_rate
);

   sbpr_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;
   logic              rsp_valid;
   sbpr_pkg::rsp_type rsp;

   // intake and classification
   sbpr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .req_burst_end (req_burst_end),
      .req_dtr_bit   (req_dtr_bit),
      .req_new_baud  (req_new_baud),
      .cmd           (cmd),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop)
   );

   // execution and result register
   sbpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // result item fields
   assign rsp_empty          = !rsp_valid;
   assign rsp_kind           = rsp.kind;
   assign rsp_out_byte       = rsp.out_byte;
   assign rsp_read_valid     = rsp.read_valid;
   assign rsp_write_accepted = rsp.write_accepted;
   assign rsp_run_last       = rsp.run_last;
   assign rsp_rearm_out      = rsp.rearm_out;
   assign rsp_reboot_request = rsp.reboot_request;
   assign rsp_connected      = rsp.connected;
   assign rsp_rx_available   = rsp.rx_available;
   assign rsp_baud_rate      = rsp.baud_rate;

endmodule

/* dv/sbpr_result_checker.sv */
// checker that predicts every serial bridge result and compares it with the block's output
`timescale 1ns / 1ps

module sbpr_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_burst_end,
   input  logic        req_dtr_bit,
   input  logic [31:0] req_new_baud,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_kind,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_read_valid,
   input  logic        rsp_write_accepted,
   input  logic        rsp_run_last,
   input  logic        rsp_rearm_out,
   input  logic        rsp_reboot_request,
   input  logic        rsp_connected,
   input  logic [8:0]  rsp_rx_available,
   input  logic [31:0] rsp_baud_rate,
   output int          mismatch_count,
   output int          pending_count,
   output int          result_count,
   output int          packet_byte_count
);

   localparam int TXW      = sbpr_pkg::TX_DEPTH_LOG2;
   localparam int RXW      = sbpr_pkg::RX_DEPTH_LOG2;
   localparam int TX_DEPTH = 1 << TXW;
   localparam int RX_DEPTH = 1 << RXW;

   // predicted ring and link state
   logic [7:0]                  tx_mem [TX_DEPTH];
   logic [TXW-1:0]              tx_wr;
   logic [TXW-1:0]              tx_rd;
   logic                        tx_busy;
   logic [7:0]                  rx_mem [RX_DEPTH];
   logic [RXW-1:0]              rx_wr;
   logic [RXW-1:0]              rx_rd;
   logic                        rx_hold;
   logic                        dtr_q;
   logic                        cfg_q;
   logic [sbpr_pkg::BAUD_W-1:0] baud_q;
   int                          out_len;
   logic [7:0]                  pkt_bytes [sbpr_pkg::PACKET_BYTES];

   // results predicted but not yet seen, oldest first
   sbpr_pkg::rsp_type due_results [$];

   function automatic logic [TXW-1:0] tx_level();
      return tx_wr - tx_rd;
   endfunction

   function automatic logic [RXW-1:0] rx_level();
      return rx_wr - rx_rd;
   endfunction

   function automatic int rx_room();
      return (RX_DEPTH - 1) - int'(rx_level());
   endfunction

   // take up to one packet of queued bytes when configured and no packet is in flight
   task automatic launch_packet(output int n);
      logic [TXW-1:0] idx;
      int             i;
      n = 0;
      if (!tx_busy && cfg_q) begin
         n = (int'(tx_level()) > sbpr_pkg::PACKET_BYTES) ? sbpr_pkg::PACKET_BYTES
                                                          : int'(tx_level());
         idx = tx_rd;
         for (i = 0; i < n; i++) begin
            pkt_bytes[i] = tx_mem[idx];
            idx++;
         end
         tx_rd = idx;
         if (n > 0) tx_busy = 1'b1;
      end
   endtask

   task automatic clear_bridge();
      tx_wr   = '0;
      tx_rd   = '0;
      tx_busy = 1'b0;
      rx_wr   = '0;
      rx_rd   = '0;
      rx_hold = 1'b0;
      dtr_q   = 1'b0;
      cfg_q   = 1'b0;
      baud_q  = sbpr_pkg::BAUD_DEFAULT;
      out_len = 0;
   endtask

   // run one item against the predicted state and queue the results it causes
   task automatic advance_bridge(input logic [2:0] act, input logic [7:0] dbyte,
                                 input logic last, input logic dtr,
                                 input logic [sbpr_pkg::BAUD_W-1:0] baud);
      int                npkt;
      int                k;
      sbpr_pkg::rsp_type rec;
      npkt = 0;
      rec  = '0;
      rec.kind = sbpr_pkg::KIND_STATUS;
      case (act)
         sbpr_pkg::ACT_APP_WRITE: begin
            if (cfg_q) begin
               if (int'(tx_level()) < TX_DEPTH - 1) begin
                  tx_mem[tx_wr] = dbyte;
                  tx_wr++;
                  rec.write_accepted = 1'b1;
               end
               if (last) launch_packet(npkt);
            end
         end
         sbpr_pkg::ACT_APP_READ: begin
            if (rx_level() != '0) begin
               rec.out_byte   = rx_mem[rx_rd];
               rec.read_valid = 1'b1;
               rx_rd++;
            end
            if (rx_hold && rx_room() >= sbpr_pkg::PACKET_BYTES) begin
               rx_hold       = 1'b0;
               rec.rearm_out = 1'b1;
            end
         end
         sbpr_pkg::ACT_HOST_OUT: begin
            // bytes past one packet length are dropped
            if (out_len < sbpr_pkg::PACKET_BYTES) begin
               if (rx_room() > 0) begin
                  rx_mem[rx_wr] = dbyte;
                  rx_wr++;
               end
               out_len++;
            end
            if (last) begin
               out_len = 0;
               if (rx_room() >= sbpr_pkg::PACKET_BYTES) rec.rearm_out = 1'b1;
               else rx_hold = 1'b1;
            end
         end
         sbpr_pkg::ACT_IN_TAKEN: begin
            tx_busy = 1'b0;
            launch_packet(npkt);
         end
         sbpr_pkg::ACT_CONFIGURE: begin
            cfg_q         = 1'b1;
            rec.rearm_out = 1'b1;
         end
         sbpr_pkg::ACT_BUS_RESET: begin
            tx_wr   = '0;
            tx_rd   = '0;
            tx_busy = 1'b0;
            rx_wr   = '0;
            rx_rd   = '0;
            rx_hold = 1'b0;
            dtr_q   = 1'b0;
            cfg_q   = 1'b0;
            out_len = 0;
         end
         sbpr_pkg::ACT_LINE_STATE: begin
            dtr_q = dtr;
            if (!dtr && baud_q == sbpr_pkg::BAUD_TOUCH) rec.reboot_request = 1'b1;
         end
         sbpr_pkg::ACT_SET_BAUD: begin
            baud_q = baud;
         end
         default: begin
         end
      endcase
      rec.connected    = cfg_q && dtr_q;
      rec.rx_available = rx_level();
      rec.baud_rate    = baud_q;
      if (npkt == 0) begin
         rec.run_last = 1'b1;
         due_results.push_back(rec);
      end else begin
         for (k = 0; k < npkt; k++) begin
            rec.kind       = sbpr_pkg::KIND_PACKET;
            rec.out_byte   = pkt_bytes[k];
            rec.read_valid = 1'b0;
            rec.run_last   = (k == npkt - 1);
            due_results.push_back(rec);
         end
      end
   endtask

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("result %0d: %s expected 0x%0h, got 0x%0h",
                     result_count, fname, want, got);
      end
   endtask

   // predict on accepted items, compare on accepted results
   always @(posedge clock) begin
      sbpr_pkg::rsp_type seen;
      sbpr_pkg::rsp_type want;
      if (reset) begin
         clear_bridge();
         due_results.delete();
         mismatch_count    = 0;
         result_count      = 0;
         packet_byte_count = 0;
      end else begin
         if (req_push && !req_full)
            advance_bridge(req_action, req_data_byte, req_burst_end, req_dtr_bit,
                           req_new_baud);
         if (!rsp_empty && rsp_pop) begin
            seen.kind           = rsp_kind;
            seen.out_byte       = rsp_out_byte;
            seen.read_valid     = rsp_read_valid;
            seen.write_accepted = rsp_write_accepted;
            seen.run_last       = rsp_run_last;
            seen.rearm_out      = rsp_rearm_out;
            seen.reboot_request = rsp_reboot_request;
            seen.connected      = rsp_connected;
            seen.rx_available   = rsp_rx_available;
            seen.baud_rate      = rsp_baud_rate;
            if (due_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d arrived with nothing predicted, kind %0d byte 0x%0h",
                           result_count, seen.kind, seen.out_byte);
            end else begin
               want = due_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(seen.kind));
               check_field("out_byte", 32'(want.out_byte), 32'(seen.out_byte));
               check_field("read_valid", 32'(want.read_valid), 32'(seen.read_valid));
               check_field("write_accepted", 32'(want.write_accepted),
                           32'(seen.write_accepted));
               check_field("run_last", 32'(want.run_last), 32'(seen.run_last));
               check_field("rearm_out", 32'(want.rearm_out), 32'(seen.rearm_out));
               check_field("reboot_request", 32'(want.reboot_request),
                           32'(seen.reboot_request));
               check_field("connected", 32'(want.connected), 32'(seen.connected));
               check_field("rx_available", 32'(want.rx_available),
                           32'(seen.rx_available));
               check_field("baud_rate", want.baud_rate, seen.baud_rate);
               if (want.kind == sbpr_pkg::KIND_PACKET) packet_byte_count++;
            end
            result_count++;
         end
      end
      pending_count = due_results.size();
   end

endmodule

/* dv/testbench.sv */
// stimulus and verdict for the serial bridge core with its result checker
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 130;
   localparam int LONG_HOLD    = 300;
   localparam int SHORT_PACKET = 16;
   localparam int READ_BURST   = 24;
   localparam int HOLD_WRITES  = 96;

   typedef enum logic [1:0] {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_STRIDE} pop_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_action = sbpr_pkg::ACT_APP_READ;
   logic [7:0]  req_data_byte = '0;
   logic        req_burst_end = 1'b0;
   logic        req_dtr_bit = 1'b0;
   logic [31:0] req_new_baud = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic        rsp_read_valid;
   logic        rsp_write_accepted;
   logic        rsp_run_last;
   logic        rsp_rearm_out;
   logic        rsp_reboot_request;
   logic        rsp_connected;
   logic [8:0]  rsp_rx_available;
   logic [31:0] rsp_baud_rate;

   int mismatch_count;
   int pending_count;
   int result_count;
   int packet_byte_count;

   int           items_sent  = 0;
   int           burst_left  = 0;
   int           hold_asks   = 0;
   int           hold_served = 0;
   int           hold_left   = 0;
   int           phase_left  = 0;
   int           cycle_count = 0;
   pop_mode_type pop_mode    = POP_ALWAYS;

   always #4 clock = ~clock;

   serial_bridge_packet_rings_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .req_burst_end      (req_burst_end),
      .req_dtr_bit        (req_dtr_bit),
      .req_new_baud       (req_new_baud),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_write_accepted (rsp_write_accepted),
      .rsp_run_last       (rsp_run_last),
      .rsp_rearm_out      (rsp_rearm_out),
      .rsp_reboot_request (rsp_reboot_request),
      .rsp_connected      (rsp_connected),
      .rsp_rx_available   (rsp_rx_available),
      .rsp_baud_rate      (rsp_baud_rate)
   );

   sbpr_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .req_burst_end      (req_burst_end),
      .req_dtr_bit        (req_dtr_bit),
      .req_new_baud       (req_new_baud),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_write_accepted (rsp_write_accepted),
      .rsp_run_last       (rsp_run_last),
      .rsp_rearm_out      (rsp_rearm_out),
      .rsp_reboot_request (rsp_reboot_request),
      .rsp_connected      (rsp_connected),
      .rsp_rx_available   (rsp_rx_available),
      .rsp_baud_rate      (rsp_baud_rate),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .result_count       (result_count),
      .packet_byte_count  (packet_byte_count)
   );

   // receiver: long hold-offs on request, otherwise a changing pop pattern
   always @(negedge clock) begin
      if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            pop_mode   = pop_mode_type'($urandom_range(0, 3));
            phase_left = $urandom_range(8, 80);
         end
         phase_left--;
         case (pop_mode)
            POP_ALWAYS: rsp_pop <= 1'b1;
            POP_COIN:   rsp_pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: rsp_pop <= ($urandom_range(0, 3) == 0);
            default:    rsp_pop <= (phase_left % 3 == 0);
         endcase
      end
   end

   // cycle guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pending_count);
      $display("serial_bridge_packet_rings_core verification failed");
      $finish;
   end

   // present one item in bursts with random gaps, hold it until taken
   task automatic offer_item(input logic [2:0] act, input logic [7:0] dbyte,
                             input logic last, input logic dtr,
                             input logic [31:0] baud);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_push <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_push      <= 1'b1;
      req_action    <= act;
      req_data_byte <= dbyte;
      req_burst_end <= last;
      req_dtr_bit   <= dtr;
      req_new_baud  <= baud;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   // item with random content in the fields the action leaves unused
   task automatic offer_op(input logic [2:0] act, input logic last);
      offer_item(act, 8'($urandom), last, 1'($urandom), $urandom);
   endtask

   task automatic send_write_burst(input int len);
      int i;
      for (i = 0; i < len; i++) offer_op(sbpr_pkg::ACT_APP_WRITE, i == len - 1);
   endtask

   task automatic send_out_packet(input int len);
      int i;
      for (i = 0; i < len; i++) offer_op(sbpr_pkg::ACT_HOST_OUT, i == len - 1);
   endtask

   task automatic send_reads(input int n);
      repeat (n) offer_op(sbpr_pkg::ACT_APP_READ, 1'($urandom));
   endtask

   // sender pauses until every predicted result has come out
   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic int pick_len(input int short_max, input int long_max);
      if ($urandom_range(0, 7) == 0) return $urandom_range(short_max, long_max);
      return $urandom_range(1, short_max);
   endfunction

   function automatic logic [31:0] pick_baud();
      case ($urandom_range(0, 4))
         0:       return sbpr_pkg::BAUD_TOUCH;
         1:       return sbpr_pkg::BAUD_DEFAULT;
         2:       return 32'h0;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int random_start;
      int i;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners: unconfigured write, empty read, baud extremes,
      // reboot request, small packets, in-flight hold, bus reset
      offer_item(sbpr_pkg::ACT_APP_WRITE, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      offer_item(sbpr_pkg::ACT_APP_READ, 8'h00, 1'b0, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_SET_BAUD, 8'hFF, 1'b1, 1'b1, 32'h0);
      offer_item(sbpr_pkg::ACT_SET_BAUD, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF);
      offer_item(sbpr_pkg::ACT_SET_BAUD, 8'h5A, 1'b0, 1'b0, sbpr_pkg::BAUD_TOUCH);
      offer_item(sbpr_pkg::ACT_LINE_STATE, 8'h00, 1'b0, 1'b1, 32'h0);
      offer_item(sbpr_pkg::ACT_LINE_STATE, 8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
      offer_item(sbpr_pkg::ACT_CONFIGURE, 8'h00, 1'b0, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_LINE_STATE, 8'h00, 1'b0, 1'b1, 32'h0);
      offer_item(sbpr_pkg::ACT_APP_WRITE, 8'h00, 1'b0, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_APP_WRITE, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      offer_item(sbpr_pkg::ACT_APP_WRITE, 8'hA5, 1'b1, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_IN_TAKEN, 8'h00, 1'b0, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_IN_TAKEN, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      offer_item(sbpr_pkg::ACT_HOST_OUT, 8'h00, 1'b0, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_HOST_OUT, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      offer_item(sbpr_pkg::ACT_APP_READ, 8'h00, 1'b0, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_APP_READ, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      offer_item(sbpr_pkg::ACT_APP_READ, 8'h00, 1'b0, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_SET_BAUD, 8'h00, 1'b0, 1'b0, sbpr_pkg::BAUD_DEFAULT);
      offer_item(sbpr_pkg::ACT_LINE_STATE, 8'h00, 1'b0, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_BUS_RESET, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      offer_item(sbpr_pkg::ACT_APP_WRITE, 8'h5A, 1'b1, 1'b0, 32'h0);
      offer_item(sbpr_pkg::ACT_CONFIGURE, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      drain_results();

      // receive ring: oversized packet, a short one, then reads
      send_out_packet(sbpr_pkg::PACKET_BYTES + 8);
      send_out_packet(SHORT_PACKET);
      send_reads(READ_BURST);
      drain_results();

      // transmit backlog past one packet while the receiver holds off
      hold_asks++;
      for (i = 0; i < HOLD_WRITES; i++) offer_op(sbpr_pkg::ACT_APP_WRITE, 1'b0);
      offer_op(sbpr_pkg::ACT_APP_WRITE, 1'b1);
      repeat (3) offer_op(sbpr_pkg::ACT_IN_TAKEN, 1'($urandom));
      drain_results();

      // random traffic: mostly well-formed sequences, some noise
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         i = $urandom_range(0, 99);
         if (i < 24) begin
            send_write_burst(pick_len(8, sbpr_pkg::PACKET_BYTES + 16));
         end else if (i < 38) begin
            send_out_packet(pick_len(8, sbpr_pkg::PACKET_BYTES + 6));
         end else if (i < 52) begin
            send_reads(pick_len(12, 70));
         end else if (i < 62) begin
            offer_op(sbpr_pkg::ACT_IN_TAKEN, 1'($urandom));
         end else if (i < 77) begin
            case ($urandom_range(0, 2))
               0:       offer_op(sbpr_pkg::ACT_CONFIGURE, 1'($urandom));
               1:       offer_op(sbpr_pkg::ACT_LINE_STATE, 1'($urandom));
               default: offer_item(sbpr_pkg::ACT_SET_BAUD, 8'($urandom), 1'($urandom),
                                   1'($urandom), pick_baud());
            endcase
         end else if (i < 80) begin
            offer_op(sbpr_pkg::ACT_BUS_RESET, 1'($urandom));
            if ($urandom_range(0, 3) != 0) offer_op(sbpr_pkg::ACT_CONFIGURE, 1'($urandom));
         end else if (i < 83) begin
            drain_results();
         end else begin
            repeat ($urandom_range(1, 4))
               offer_item(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                          $urandom);
         end
      end

      // let the last results out, then wait a while longer for strays
      drain_results();
      repeat (20) @(negedge clock);

      $display("ran %0d items: directed corners, oversized OUT packet and reads, %s",
               items_sent, "transmit backlog under back-pressure, random traffic");
      $display("compared %0d results (%0d IN packet bytes), %0d mismatches, %0d left due",
               result_count, packet_byte_count, mismatch_count, pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("serial_bridge_packet_rings_core verification clean");
      end else begin
         $display("serial_bridge_packet_rings_core verification failed");
      end
      $finish;
   end

endmodule
